// ===== hw/rtl/tdc_time_over_threshold_unit_assert.svh =====
`ifndef TDC_TIME_OVER_THRESHOLD_UNIT_ASSERT_SVH
`define TDC_TIME_OVER_THRESHOLD_UNIT_ASSERT_SVH

// same-cycle implication, checked on every rising edge outside reset
`define TDC_TOT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TDC_TOT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/tdc_tot_pkg.sv =====
`timescale 1ns / 1ps

package tdc_tot_pkg;

   localparam int CARDS     = 1;
   localparam int CHANNELS  = 33;
   localparam int FINE_BINS = 1024;

   localparam int SETS      = CARDS * CHANNELS;
   localparam int CAL_DEPTH = SETS * FINE_BINS;
   localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int SET_AW    = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int CAL_AW    = (CAL_DEPTH > 1) ? $clog2(CAL_DEPTH) : 1;

   localparam logic [9:0]  INVALID_FINE = 10'h3ff;
   localparam int          EPOCH_PS     = 10240000;
   localparam int          COARSE_PS    = 5000;
   localparam int          FINE_SCALE   = 5000;
   localparam logic [16:0] CAL_ONE      = 17'h10000;

   typedef enum logic [1:0] {
      CMD_TDC         = 2'd0,
      CMD_START       = 2'd1,
      CMD_CAL_WRITE   = 2'd2,
      CMD_RANGE_WRITE = 2'd3
   } cmd_type;

   typedef enum logic {
      KIND_TOT   = 1'b0,
      KIND_ERROR = 1'b1
   } kind_type;

   // hit time in ps
   typedef logic signed [54:0] time_type;

endpackage

// ===== hw/rtl/tdc_tot_ram.sv =====
`timescale 1ns / 1ps

module tdc_tot_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read-first: a read of the address being written returns the old word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/tdc_time_over_threshold_unit.sv =====
`timescale 1ns / 1ps

// TDC time-over-threshold unit. Takes one TDC word or command per cycle and
// gives the time-over-threshold of each trailing edge that follows a stored
// leading edge on its channel, or an epoch-before-trigger error. Each word
// passes the s1, s2 and s3 registers into the output register. The
// per-channel lead times, epoch offsets and the calibration tables and ranges
// sit in synchronous memories with a registered read; lead times written late
// in the pipeline are forwarded to a trailing edge one word behind. Words are
// taken every cycle; the input stalls only during the clearing pass, or while
// a result is held on the output and another one reaches the last stage.
// After reset the clearing pass zeroes the calibration tables and ranges, one
// entry a cycle, over CARDS*CHANNELS*FINE_BINS entries (33792 as built), no words taken.
module tdc_time_over_threshold_unit
   import tdc_tot_pkg::*;
(
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_cmd,
   input  logic [2:0]         req_card_index,
   input  logic [27:0]        req_epoch_word,
   input  logic [6:0]         req_channel,
   input  logic [9:0]         req_fine,
   input  logic [10:0]        req_coarse,
   input  logic               req_is_leading,
   input  logic [9:0]         req_table_index,
   input  logic [16:0]        req_cal_value,
   input  logic [10:0]        req_range_low,
   input  logic [10:0]        req_range_high,

   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_kind,
   output logic [2:0]         rsp_out_card,
   output logic [5:0]         rsp_out_channel,
   output logic signed [53:0] rsp_tot_ps
);

`include "tdc_time_over_threshold_unit_assert.svh"

   // ---------------- control state ----------------
   logic                clr_busy_ff, clr_busy_in;
   logic [CAL_AW-1:0]   clr_cnt_ff, clr_cnt_in;
   logic [27:0]         trigger_epoch_ff, trigger_epoch_in;
   logic [27:0]         pending_epoch_ff, pending_epoch_in;
   logic                aborted_ff, aborted_in;
   logic [CHANNELS-1:0] lead_valid_ff, lead_valid_in;
   logic [CHANNELS-1:0] off_valid_ff, off_valid_in;

   logic adv;
   logic req_accept;

   // ---------------- stage registers ----------------
   logic                s1_emit_ff, s1_lead_wr_ff, s1_kind_ff;
   logic [2:0]          s1_card_ff;
   logic [CH_W-1:0]     s1_ch_ff;
   logic [9:0]          s1_fine_ff;
   logic [10:0]         s1_coarse_ff;
   logic                s1_uncal_ff, s1_fine_oob_ff;
   logic                s1_use_new_ff, s1_off_valid_ff;
   logic signed [28:0]  s1_off_new_ff;

   logic                s2_emit_ff, s2_lead_wr_ff, s2_kind_ff;
   logic [2:0]          s2_card_ff;
   logic [CH_W-1:0]     s2_ch_ff;
   time_type            s2_off_prod_ff;
   logic [23:0]         s2_coarse_prod_ff;
   logic [29:0]         s2_fine_prod_ff;
   logic                s2_below_ff, s2_above_ff;

   logic                s3_emit_ff, s3_lead_wr_ff, s3_kind_ff;
   logic [2:0]          s3_card_ff;
   logic [CH_W-1:0]     s3_ch_ff;
   time_type            s3_t_ff;
   logic                fwd_hit_ff;
   time_type            fwd_t_ff;

   logic                rsp_valid_ff;
   logic                rsp_kind_ff;
   logic [2:0]          rsp_card_ff;
   logic [5:0]          rsp_channel_ff;
   logic signed [53:0]  rsp_tot_ff;

   // ---------------- memory ports ----------------
   logic               cal_wr_en;
   logic [CAL_AW-1:0]  cal_wr_addr, cal_rd_addr;
   logic [16:0]        cal_wr_data, cal_rd_data;
   logic               rng_wr_en;
   logic [SET_AW-1:0]  rng_wr_addr, rng_rd_addr;
   logic [21:0]        rng_wr_data, rng_rd_data;
   logic               off_wr_en;
   logic [28:0]        off_rd_data;
   time_type           lead_rd_data;

   // ---------------- flow control ----------------
   assign adv        = !(rsp_valid_ff && rsp_stall && s3_emit_ff);
   assign req_stall  = clr_busy_ff || !adv;
   assign req_accept = req_valid && !req_stall;

   // ---------------- stage 0: decode, scalar state, table addresses ----------------
   logic [CH_W-1:0]    ch_idx;
   logic               card_ok, ch_ok, tix_ok, fine_oob;
   logic [31:0]        set_sum, cal_rd_sum, cal_wr_sum;
   logic [SET_AW-1:0]  set_idx;
   logic [16:0]        cal_sat;
   logic               tdc_live, hit_ok, pend, trig_zero, err, off_wr, proceed;
   logic               lead_wr, emit_tot, start;
   logic [27:0]        trig_base;
   logic signed [28:0] off_new;

   assign ch_idx   = req_channel[CH_W-1:0];
   assign card_ok  = 32'(req_card_index) < 32'(CARDS);
   assign ch_ok    = 32'(req_channel) < 32'(CHANNELS);
   assign tix_ok   = 32'(req_table_index) < 32'(FINE_BINS);
   assign fine_oob = 32'(req_fine) >= 32'(FINE_BINS);
   assign set_sum  = 32'(req_card_index) * 32'(CHANNELS) + 32'(req_channel);
   assign set_idx  = set_sum[SET_AW-1:0];
   assign cal_rd_sum = 32'(set_idx) * 32'(FINE_BINS) + 32'(req_fine);
   assign cal_wr_sum = 32'(set_idx) * 32'(FINE_BINS) + 32'(req_table_index);
   assign cal_sat  = (req_cal_value > CAL_ONE) ? CAL_ONE : req_cal_value;

   assign start     = req_accept && (req_cmd == CMD_START);
   assign tdc_live  = req_accept && (req_cmd == CMD_TDC) && !aborted_ff;
   assign hit_ok    = tdc_live && (req_epoch_word == '0) && (req_fine != INVALID_FINE) && ch_ok;
   assign pend      = pending_epoch_ff != '0;
   assign trig_zero = trigger_epoch_ff == '0;
   // a hit off channel 0 with an epoch pending before any trigger epoch aborts the card
   assign err       = hit_ok && pend && trig_zero && (req_channel != '0);
   assign off_wr    = hit_ok && pend && !err;
   assign trig_base = trig_zero ? pending_epoch_ff : trigger_epoch_ff;
   assign off_new   = signed'({1'b0, pending_epoch_ff}) - signed'({1'b0, trig_base});
   assign proceed   = hit_ok && !err;
   assign lead_wr   = proceed && req_is_leading;
   assign emit_tot  = proceed && !req_is_leading && lead_valid_ff[ch_idx];

   always_comb begin
      clr_busy_in      = clr_busy_ff;
      clr_cnt_in       = clr_cnt_ff;
      trigger_epoch_in = trigger_epoch_ff;
      pending_epoch_in = pending_epoch_ff;
      aborted_in       = aborted_ff;
      lead_valid_in    = lead_valid_ff;
      off_valid_in     = off_valid_ff;

      if (clr_busy_ff) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (32'(clr_cnt_ff) == 32'(CAL_DEPTH - 1)) begin
            clr_busy_in = 1'b0;
         end
      end

      if (start) begin
         trigger_epoch_in = '0;
         pending_epoch_in = '0;
         aborted_in       = 1'b0;
         lead_valid_in    = '0;
         off_valid_in     = '0;
      end else if (tdc_live && (req_epoch_word != '0)) begin
         pending_epoch_in = req_epoch_word;
      end else if (err) begin
         aborted_in = 1'b1;
      end else if (proceed) begin
         if (off_wr) begin
            pending_epoch_in     = '0;
            off_valid_in[ch_idx] = 1'b1;
            if (trig_zero) begin
               trigger_epoch_in = pending_epoch_ff;
            end
         end
         if (lead_wr) begin
            lead_valid_in[ch_idx] = 1'b1;
         end else if (emit_tot) begin
            lead_valid_in[ch_idx] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff      <= 1'b1;
         clr_cnt_ff       <= '0;
         trigger_epoch_ff <= '0;
         pending_epoch_ff <= '0;
         aborted_ff       <= 1'b0;
         lead_valid_ff    <= '0;
         off_valid_ff     <= '0;
      end else begin
         clr_busy_ff      <= clr_busy_in;
         clr_cnt_ff       <= clr_cnt_in;
         trigger_epoch_ff <= trigger_epoch_in;
         pending_epoch_ff <= pending_epoch_in;
         aborted_ff       <= aborted_in;
         lead_valid_ff    <= lead_valid_in;
         off_valid_ff     <= off_valid_in;
      end
   end

   // calibration and range writes share the port with the clearing pass
   always_comb begin
      if (clr_busy_ff) begin
         cal_wr_en   = 1'b1;
         cal_wr_addr = clr_cnt_ff;
         cal_wr_data = '0;
         rng_wr_en   = 32'(clr_cnt_ff) < 32'(SETS);
         rng_wr_addr = clr_cnt_ff[SET_AW-1:0];
         rng_wr_data = '0;
      end else begin
         cal_wr_en   = req_accept && (req_cmd == CMD_CAL_WRITE) && card_ok && ch_ok && tix_ok;
         cal_wr_addr = cal_wr_sum[CAL_AW-1:0];
         cal_wr_data = cal_sat;
         rng_wr_en   = req_accept && (req_cmd == CMD_RANGE_WRITE) && card_ok && ch_ok;
         rng_wr_addr = set_idx;
         rng_wr_data = {req_range_high, req_range_low};
      end
   end

   assign cal_rd_addr = cal_rd_sum[CAL_AW-1:0];
   assign rng_rd_addr = set_idx;
   assign off_wr_en   = off_wr;

   tdc_tot_ram #(.WIDTH(17), .DEPTH(CAL_DEPTH)) u_cal_ram (
      .clock   (clock),
      .wr_en   (cal_wr_en),
      .wr_addr (cal_wr_addr),
      .wr_data (cal_wr_data),
      .rd_en   (adv),
      .rd_addr (cal_rd_addr),
      .rd_data (cal_rd_data)
   );

   tdc_tot_ram #(.WIDTH(22), .DEPTH(SETS)) u_range_ram (
      .clock   (clock),
      .wr_en   (rng_wr_en),
      .wr_addr (rng_wr_addr),
      .wr_data (rng_wr_data),
      .rd_en   (adv),
      .rd_addr (rng_rd_addr),
      .rd_data (rng_rd_data)
   );

   tdc_tot_ram #(.WIDTH(29), .DEPTH(CHANNELS)) u_offset_ram (
      .clock   (clock),
      .wr_en   (off_wr_en),
      .wr_addr (ch_idx),
      .wr_data (off_new),
      .rd_en   (adv),
      .rd_addr (ch_idx),
      .rd_data (off_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_emit_ff    <= 1'b0;
         s1_lead_wr_ff <= 1'b0;
      end else if (adv) begin
         s1_emit_ff    <= err || emit_tot;
         s1_lead_wr_ff <= lead_wr;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_kind_ff      <= err ? KIND_ERROR : KIND_TOT;
         s1_card_ff      <= req_card_index;
         s1_ch_ff        <= ch_idx;
         s1_fine_ff      <= req_fine;
         s1_coarse_ff    <= req_coarse;
         s1_uncal_ff     <= !card_ok;
         s1_fine_oob_ff  <= fine_oob;
         s1_use_new_ff   <= off_wr;
         s1_off_new_ff   <= off_new;
         s1_off_valid_ff <= ch_ok && off_valid_ff[ch_idx];
      end
   end

   // ---------------- stage 1: products and range compare ----------------
   logic signed [28:0] off_sel;
   logic [21:0]        rng_sel;
   logic [16:0]        q_sel;

   assign off_sel = s1_use_new_ff   ? s1_off_new_ff :
                    s1_off_valid_ff ? signed'(off_rd_data) : '0;
   assign rng_sel = s1_uncal_ff ? '0 : rng_rd_data;
   assign q_sel   = (s1_uncal_ff || s1_fine_oob_ff) ? '0 : cal_rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_emit_ff    <= 1'b0;
         s2_lead_wr_ff <= 1'b0;
      end else if (adv) begin
         s2_emit_ff    <= s1_emit_ff;
         s2_lead_wr_ff <= s1_lead_wr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_kind_ff        <= s1_kind_ff;
         s2_card_ff        <= s1_card_ff;
         s2_ch_ff          <= s1_ch_ff;
         s2_off_prod_ff    <= time_type'(off_sel) * time_type'(EPOCH_PS);
         s2_coarse_prod_ff <= 24'(s1_coarse_ff) * 24'(COARSE_PS);
         s2_fine_prod_ff   <= 30'(q_sel) * 30'(FINE_SCALE);
         s2_below_ff       <= {1'b0, s1_fine_ff} < rng_sel[10:0];
         s2_above_ff       <= {1'b0, s1_fine_ff} > rng_sel[21:11];
      end
   end

   // ---------------- stage 2: hit time, lead read ----------------
   logic [12:0]        calfine;
   logic signed [24:0] frac_ps;
   time_type           t_ps;

   // below the range counts first, also when the range is inverted
   assign calfine = s2_below_ff ? '0 :
                    s2_above_ff ? 13'(FINE_SCALE) : s2_fine_prod_ff[28:16];
   assign frac_ps = signed'({1'b0, s2_coarse_prod_ff}) - signed'({12'b0, calfine});
   assign t_ps    = s2_off_prod_ff + time_type'(frac_ps);

   tdc_tot_ram #(.WIDTH(55), .DEPTH(CHANNELS)) u_lead_ram (
      .clock   (clock),
      .wr_en   (adv && s3_lead_wr_ff),
      .wr_addr (s3_ch_ff),
      .wr_data (s3_t_ff),
      .rd_en   (adv),
      .rd_addr (s2_ch_ff),
      .rd_data (lead_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_emit_ff    <= 1'b0;
         s3_lead_wr_ff <= 1'b0;
         fwd_hit_ff    <= 1'b0;
      end else if (adv) begin
         s3_emit_ff    <= s2_emit_ff;
         s3_lead_wr_ff <= s2_lead_wr_ff;
         // lead written in the same cycle as this read: take it directly
         fwd_hit_ff    <= s3_lead_wr_ff && (s3_ch_ff == s2_ch_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_kind_ff <= s2_kind_ff;
         s3_card_ff <= s2_card_ff;
         s3_ch_ff   <= s2_ch_ff;
         s3_t_ff    <= t_ps;
         fwd_t_ff   <= s3_t_ff;
      end
   end

   // ---------------- stage 3: difference into the output register ----------------
   time_type lead_sel;
   time_type tot_full;

   assign lead_sel = fwd_hit_ff ? fwd_t_ff : lead_rd_data;
   assign tot_full = s3_t_ff - lead_sel;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv && s3_emit_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && s3_emit_ff) begin
         rsp_kind_ff    <= s3_kind_ff;
         rsp_card_ff    <= s3_card_ff;
         rsp_channel_ff <= 6'(s3_ch_ff);
         rsp_tot_ff     <= (s3_kind_ff == KIND_ERROR) ? '0 : tot_full[53:0];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_out_card    = rsp_card_ff;
   assign rsp_out_channel = rsp_channel_ff;
   assign rsp_tot_ps      = rsp_tot_ff;

   // ---------------- assertions ----------------
   `TDC_TOT_ASSERT_NEXT(a_aborted_quiet, req_accept && (req_cmd == CMD_TDC) && aborted_ff, !s1_emit_ff && !s1_lead_wr_ff, "tdc word acted on while aborted")
   `TDC_TOT_ASSERT_NOW(a_error_zero_tot, rsp_valid_ff && (rsp_kind_ff == KIND_ERROR), rsp_tot_ff == '0, "error result with nonzero tot")
   `TDC_TOT_ASSERT_NEXT(a_trigger_kept, (trigger_epoch_ff != '0) && !start, trigger_epoch_ff == $past(trigger_epoch_ff), "trigger epoch changed within a card")

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import tdc_tot_pkg::*;

   localparam int IDLE_LIMIT = 200000;  // covers the calibration clearing pass after reset
   localparam int HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES = 20;
   localparam int CALM_WORDS = 300;

   typedef struct {
      cmd_type     cmd;
      logic [2:0]  card;
      logic [27:0] epoch;
      logic [6:0]  channel;
      logic [9:0]  fine;
      logic [10:0] coarse;
      logic        leading;
      logic [9:0]  tix;
      logic [16:0] cal;
      logic [10:0] rlo;
      logic [10:0] rhi;
      bit          sync_point;
   } tdc_word_type;

   typedef struct {
      kind_type           kind;
      logic [2:0]         card;
      logic [5:0]         channel;
      logic signed [53:0] tot;
   } tot_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_cmd = CMD_START;
   logic [2:0]  req_card_index = '0;
   logic [27:0] req_epoch_word = '0;
   logic [6:0]  req_channel = '0;
   logic [9:0]  req_fine = '0;
   logic [10:0] req_coarse = '0;
   logic        req_is_leading = 1'b0;
   logic [9:0]  req_table_index = '0;
   logic [16:0] req_cal_value = '0;
   logic [10:0] req_range_low = '0;
   logic [10:0] req_range_high = '0;

   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_kind;
   logic [2:0]         rsp_out_card;
   logic [5:0]         rsp_out_channel;
   logic signed [53:0] rsp_tot_ps;

   tdc_time_over_threshold_unit DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_card_index  (req_card_index),
      .req_epoch_word  (req_epoch_word),
      .req_channel     (req_channel),
      .req_fine        (req_fine),
      .req_coarse      (req_coarse),
      .req_is_leading  (req_is_leading),
      .req_table_index (req_table_index),
      .req_cal_value   (req_cal_value),
      .req_range_low   (req_range_low),
      .req_range_high  (req_range_high),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_out_card    (rsp_out_card),
      .rsp_out_channel (rsp_out_channel),
      .rsp_tot_ps      (rsp_tot_ps)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------- predictor state
   longint      lead_ps [CHANNELS];
   bit          lead_held [CHANNELS];
   int          epoch_offset [CHANNELS];
   logic [27:0] trigger_epoch_q;
   logic [27:0] held_epoch;
   bit          card_aborted;
   logic [16:0] cal_table [CAL_DEPTH];
   logic [10:0] band_low [SETS];
   logic [10:0] band_high [SETS];

   tdc_word_type   word_queue [$];
   tot_result_type tot_expected [$];
   tdc_word_type   in_flight;

   int  mismatches = 0;
   int  words_taken = 0;
   int  idle_cycles = 0;
   int  cycle_count = 0;
   int  gap_left = 0;
   int  stall_left = 0;
   int  hold_left = 0;
   bit  hold_done = 0;
   bit  draining = 0;
   bit  taken = 0;
   bit  calm;
   bit  quiet;

   assign calm  = word_queue.size() < CALM_WORDS;
   assign quiet = cycle_count[9:8] == 2'd0;

   function automatic void clear_card_state();
      foreach (lead_held[i]) begin
         lead_held[i] = 0;
         epoch_offset[i] = 0;
      end
      trigger_epoch_q = '0;
      held_epoch = '0;
      card_aborted = 0;
   endfunction

   function automatic void predict_tot(input tdc_word_type w);
      int             set;
      logic [10:0]    lo;
      logic [10:0]    hi;
      logic [16:0]    q;
      longint         fcal;
      longint         t;
      longint         tot;
      tot_result_type r;
      case (w.cmd)
         CMD_START: clear_card_state();
         CMD_CAL_WRITE: begin
            if (w.card < CARDS && w.channel < CHANNELS && w.tix < FINE_BINS)
               cal_table[(w.card * CHANNELS + w.channel) * FINE_BINS + w.tix] =
                  (w.cal > CAL_ONE) ? CAL_ONE : w.cal;
         end
         CMD_RANGE_WRITE: begin
            if (w.card < CARDS && w.channel < CHANNELS) begin
               band_low[w.card * CHANNELS + w.channel]  = w.rlo;
               band_high[w.card * CHANNELS + w.channel] = w.rhi;
            end
         end
         default: begin
            if (card_aborted) return;
            if (w.epoch != 0) begin
               held_epoch = w.epoch;
               return;
            end
            if (w.fine == INVALID_FINE || w.channel >= CHANNELS) return;
            if (held_epoch != 0) begin
               if (trigger_epoch_q == 0 && w.channel == 0) begin
                  trigger_epoch_q = held_epoch;
               end else if (trigger_epoch_q == 0) begin
                  // epoch arrived ahead of any trigger: abort this card
                  card_aborted = 1;
                  r.kind = KIND_ERROR;
                  r.card = w.card;
                  r.channel = w.channel[5:0];
                  r.tot = '0;
                  tot_expected.push_back(r);
                  return;
               end
               epoch_offset[w.channel] = int'(held_epoch) - int'(trigger_epoch_q);
               held_epoch = '0;
            end
            lo = '0;
            hi = '0;
            q = '0;
            if (w.card < CARDS) begin
               set = w.card * CHANNELS + w.channel;
               lo = band_low[set];
               hi = band_high[set];
               if (w.fine < FINE_BINS) q = cal_table[set * FINE_BINS + w.fine];
            end
            if (w.fine < lo) fcal = 0;
            else if (w.fine > hi) fcal = longint'(FINE_SCALE);
            else fcal = (longint'(q) * FINE_SCALE) >>> 16;
            t = longint'(epoch_offset[w.channel]) * EPOCH_PS
              + longint'(w.coarse) * COARSE_PS - fcal;
            if (w.leading) begin
               lead_ps[w.channel] = t;
               lead_held[w.channel] = 1;
            end else if (lead_held[w.channel]) begin
               tot = t - lead_ps[w.channel];
               lead_held[w.channel] = 0;
               r.kind = KIND_TOT;
               r.card = w.card;
               r.channel = w.channel[5:0];
               r.tot = tot[53:0];
               tot_expected.push_back(r);
            end
         end
      endcase
   endfunction

   // ---------------------------------------------------------------- stimulus builders
   function automatic tdc_word_type noise_word();
      tdc_word_type w;
      w.cmd = cmd_type'($urandom_range(0, 3));
      w.card = 3'($urandom_range(0, 7));
      w.epoch = ($urandom_range(0, 1) == 0) ? 28'd0 : 28'($urandom());
      w.channel = 7'($urandom_range(0, 127));
      w.fine = 10'($urandom_range(0, 1023));
      w.coarse = 11'($urandom_range(0, 2047));
      w.leading = 1'($urandom_range(0, 1));
      w.tix = 10'($urandom_range(0, 1023));
      w.cal = 17'($urandom_range(0, 17'h1ffff));
      w.rlo = 11'($urandom_range(0, 2047));
      w.rhi = 11'($urandom_range(0, 2047));
      w.sync_point = 0;
      return w;
   endfunction

   function automatic logic [2:0] pick_card();
      return ($urandom_range(0, 11) == 0) ? 3'($urandom_range(1, 7)) : 3'd0;
   endfunction

   function automatic tdc_word_type make_cmd(input cmd_type c);
      tdc_word_type w;
      w = noise_word();
      w.cmd = c;
      w.card = pick_card();
      w.channel = ($urandom_range(0, 15) == 0) ? 7'($urandom_range(33, 127))
                                               : 7'($urandom_range(0, 32));
      return w;
   endfunction

   function automatic tdc_word_type make_hit(input logic [6:0] ch, input logic lead,
                                             input logic [9:0] fine);
      tdc_word_type w;
      w = make_cmd(CMD_TDC);
      w.epoch = '0;
      w.channel = ch;
      w.leading = lead;
      w.fine = fine;
      return w;
   endfunction

   function automatic tdc_word_type make_epoch(input logic [27:0] value);
      tdc_word_type w;
      w = make_cmd(CMD_TDC);
      w.epoch = value;
      return w;
   endfunction

   function automatic tdc_word_type make_range(input logic [6:0] ch, input logic [10:0] lo,
                                               input logic [10:0] hi);
      tdc_word_type w;
      w = make_cmd(CMD_RANGE_WRITE);
      w.card = '0;
      w.channel = ch;
      w.rlo = lo;
      w.rhi = hi;
      return w;
   endfunction

   function automatic tdc_word_type make_cal(input logic [2:0] card, input logic [6:0] ch,
                                             input logic [9:0] tix, input logic [16:0] value);
      tdc_word_type w;
      w = make_cmd(CMD_CAL_WRITE);
      w.card = card;
      w.channel = ch;
      w.tix = tix;
      w.cal = value;
      return w;
   endfunction

   function automatic logic [27:0] rand_epoch();
      return ($urandom_range(0, 1) == 0) ? 28'($urandom_range(1, 64))
                                         : 28'($urandom_range(1, 28'hfffffff));
   endfunction

   function automatic logic [9:0] rand_fine(input logic [9:0] recent_tix);
      int sel;
      sel = $urandom_range(0, 29);
      if (sel == 0) return INVALID_FINE;
      if (sel < 10) return recent_tix;
      return 10'($urandom_range(0, 1022));
   endfunction

   // ---------------------------------------------------------------- driver
   always @(negedge clock) begin
      tdc_word_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (draining) begin
            if (tot_expected.size() == 0) draining = 0;
            req_valid <= 1'b0;
         end else if (word_queue.size() > 0) begin
            nxt = word_queue.pop_front();
            if (nxt.sync_point) begin
               draining = 1;
               req_valid <= 1'b0;
            end else begin
               in_flight = nxt;
               req_cmd         <= nxt.cmd;
               req_card_index  <= nxt.card;
               req_epoch_word  <= nxt.epoch;
               req_channel     <= nxt.channel;
               req_fine        <= nxt.fine;
               req_coarse      <= nxt.coarse;
               req_is_leading  <= nxt.leading;
               req_table_index <= nxt.tix;
               req_cal_value   <= nxt.cal;
               req_range_low   <= nxt.rlo;
               req_range_high  <= nxt.rhi;
               req_valid       <= 1'b1;
               if (!calm && !quiet && $urandom_range(0, 9) == 0)
                  gap_left = $urandom_range(1, 10);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
      taken = 0;
   end

   // ---------------------------------------------------------------- receiver back-pressure
   always @(negedge clock) begin
      if (!hold_done && words_taken >= 700) begin
         hold_done = 1;
         hold_left = HOLD_CYCLES;
      end
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (!calm && !quiet && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 9);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // ---------------------------------------------------------------- monitor
   always @(posedge clock) begin
      tot_result_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (tot_expected.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected result kind=%0d card=%0d channel=%0d tot=%0d",
                        $time, rsp_kind, rsp_out_card, rsp_out_channel, rsp_tot_ps);
            end else begin
               want = tot_expected.pop_front();
               if (rsp_kind !== want.kind) begin
                  mismatches++;
                  $display("%0t: kind expected %0d actual %0d", $time, want.kind, rsp_kind);
               end
               if (rsp_out_card !== want.card) begin
                  mismatches++;
                  $display("%0t: card expected %0d actual %0d", $time, want.card,
                           rsp_out_card);
               end
               if (rsp_out_channel !== want.channel) begin
                  mismatches++;
                  $display("%0t: channel expected %0d actual %0d", $time, want.channel,
                           rsp_out_channel);
               end
               if (rsp_tot_ps !== want.tot) begin
                  mismatches++;
                  $display("%0t: tot_ps expected %0d actual %0d", $time, want.tot,
                           rsp_tot_ps);
               end
            end
         end
         if (req_valid && !req_stall) begin
            predict_tot(in_flight);
            taken = 1;
            words_taken++;
         end
      end
   end

   // ---------------------------------------------------------------- watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
         $display("Verification failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- stimulus and end of run
   initial begin
      int           useful;
      int           n;
      int           sel;
      bit           paused;
      logic [6:0]   ch;
      logic [9:0]   recent_tix;
      tdc_word_type w;

      for (int i = 0; i < CAL_DEPTH; i++) cal_table[i] = '0;
      for (int i = 0; i < SETS; i++) begin
         band_low[i] = '0;
         band_high[i] = '0;
      end
      clear_card_state();

      // directed part
      word_queue.push_back(make_cmd(CMD_START));
      word_queue.push_back(make_range(7'd1, 11'd100, 11'd900));
      word_queue.push_back(make_cal(3'd0, 7'd1, 10'd500, 17'h10000));
      word_queue.push_back(make_cal(3'd0, 7'd1, 10'd200, 17'h1ffff));   // saturates
      word_queue.push_back(make_cal(3'd0, 7'd127, 10'd500, 17'd1234));  // channel too high
      word_queue.push_back(make_cal(3'd7, 7'd1, 10'd500, 17'd99));      // card out of range
      word_queue.push_back(make_range(7'd2, 11'd600, 11'd300));         // low above high
      word_queue.push_back(make_range(7'd32, 11'd0, 11'd2047));
      word_queue.push_back(make_epoch(28'd5));
      word_queue.push_back(make_hit(7'd0, 1'b1, 10'd0));
      word_queue.push_back(make_epoch(28'hfffffff));
      word_queue.push_back(make_hit(7'd1, 1'b1, 10'd500));
      word_queue.push_back(make_hit(7'd1, 1'b0, 10'd200));
      word_queue.push_back(make_hit(7'd3, 1'b0, 10'd7));                // trailing, no lead
      word_queue.push_back(make_hit(7'd1, 1'b1, INVALID_FINE));
      word_queue.push_back(make_hit(7'd33, 1'b1, 10'd10));
      word_queue.push_back(make_hit(7'd127, 1'b0, 10'd10));
      w = make_hit(7'd2, 1'b1, 10'd700);
      w.card = 3'd7;
      word_queue.push_back(w);
      word_queue.push_back(make_hit(7'd2, 1'b0, 10'd100));
      word_queue.push_back(make_hit(7'd32, 1'b1, 10'd1022));
      word_queue.push_back(make_hit(7'd32, 1'b0, 10'd0));
      word_queue.push_back(make_cmd(CMD_START));
      word_queue.push_back(make_epoch(28'd9));
      word_queue.push_back(make_hit(7'd5, 1'b1, 10'd3));                // epoch before trigger
      word_queue.push_back(make_hit(7'd5, 1'b0, 10'd3));                // ignored while aborted
      w.sync_point = 1;
      word_queue.push_back(w);

      // random part: mostly well-formed card blocks
      useful = 0;
      paused = 0;
      recent_tix = 10'($urandom_range(0, 1023));
      while (useful < 1400) begin
         if (useful >= 700 && !paused) begin
            w.sync_point = 1;
            word_queue.push_back(w);
            paused = 1;
         end
         word_queue.push_back(make_cmd(CMD_START));
         if ($urandom_range(0, 9) != 0) begin
            word_queue.push_back(make_epoch(rand_epoch()));
            word_queue.push_back(make_hit(7'd0, 1'($urandom_range(0, 1)),
                                          10'($urandom_range(0, 1022))));
         end
         n = $urandom_range(4, 30);
         repeat (n) begin
            sel = $urandom_range(0, 99);
            ch = ($urandom_range(0, 19) == 0) ? 7'($urandom_range(33, 127))
                                              : 7'($urandom_range(0, 32));
            if (sel < 40) begin
               word_queue.push_back(make_hit(ch, 1'b1, rand_fine(recent_tix)));
               if (sel % 3 == 0) word_queue.push_back(make_epoch(rand_epoch()));
               else if (sel % 3 == 1)
                  word_queue.push_back(make_hit(7'($urandom_range(0, 32)),
                                                1'($urandom_range(0, 1)),
                                                rand_fine(recent_tix)));
               word_queue.push_back(make_hit(ch, 1'b0, rand_fine(recent_tix)));
               useful += 2;
            end else if (sel < 55) begin
               word_queue.push_back(make_hit(ch, 1'($urandom_range(0, 1)),
                                             rand_fine(recent_tix)));
               useful++;
            end else if (sel < 65) begin
               word_queue.push_back(make_epoch(rand_epoch()));
               useful++;
            end else if (sel < 77) begin
               recent_tix = 10'($urandom_range(0, 1023));
               word_queue.push_back(make_cal(pick_card(), ch, recent_tix,
                                             17'($urandom_range(0, 17'h1ffff))));
               useful++;
            end else if (sel < 85) begin
               if ($urandom_range(0, 3) == 0)
                  word_queue.push_back(make_range(ch, 11'($urandom_range(0, 2047)),
                                                  11'($urandom_range(0, 2047))));
               else
                  word_queue.push_back(make_range(ch, 11'($urandom_range(0, 200)),
                                                  11'($urandom_range(800, 1024))));
               useful++;
            end else begin
               word_queue.push_back(noise_word());
            end
         end
      end

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      do @(posedge clock);
      while (word_queue.size() != 0 || req_valid || draining || tot_expected.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatches == 0 && tot_expected.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
